// File: design/aclt_pkg.sv
package aclt_pkg;

   localparam int ADDR_W    = 32;
   localparam int BLK_W     = 29;
   localparam int CNT_W     = 16;
   localparam int HIT_W     = 32;
   localparam int WAY_OUT_W = 2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [HIT_W-1:0]  total_type;

   localparam count_type CNT_MAX = '1;
   localparam count_type CNT_ONE = count_type'(1);
   localparam total_type HIT_MAX = '1;

endpackage

// File: design/aclt_div.sv
module aclt_div
   import aclt_pkg::*;
#(
   parameter int BLOCK_BYTES = 8,
   parameter int Q_WIDTH     = 29
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  addr_type           in_address,
   output logic               out_valid,
   output logic [Q_WIDTH-1:0] out_quot
);

   // Divide by a constant: multiply by a rounded reciprocal, then fix up.
   localparam int SH_L = $clog2(BLOCK_BYTES);
   localparam int SH_POST = (SH_L == 0) ? 0 : SH_L - 1;
   localparam logic [63:0] MAGIC_WIDE =
      ((64'd1 << ADDR_W) * ((64'd1 << SH_L) - 64'(BLOCK_BYTES))) / 64'(BLOCK_BYTES) + 64'd1;
   localparam addr_type MAGIC = MAGIC_WIDE[ADDR_W-1:0];

   logic                 s1_valid_ff;
   addr_type             s1_addr_ff;
   addr_type             s1_high_ff;
   logic [2*ADDR_W-1:0]  product;
   addr_type             fix_sum;
   logic                 s2_valid_ff;
   logic [Q_WIDTH-1:0]   s2_quot_ff;
   logic [Q_WIDTH-1:0]   s2_quot_in;

   assign product = 64'(in_address) * 64'(MAGIC);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_addr_ff <= in_address;
      s1_high_ff <= product[2*ADDR_W-1:ADDR_W];
      s2_quot_ff <= s2_quot_in;
   end

   always_comb begin
      fix_sum = s1_high_ff + ((s1_addr_ff - s1_high_ff) >> 1);
      if (BLOCK_BYTES == 1) begin
         s2_quot_in = Q_WIDTH'(s1_addr_ff);
      end else begin
         s2_quot_in = Q_WIDTH'(fix_sum >> SH_POST);
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_quot  = s2_quot_ff;

endmodule

// File: design/aclt_store.sv
module aclt_store
   import aclt_pkg::*;
#(
   parameter int WAYS    = 4,
   parameter int Q_WIDTH = 29
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [Q_WIDTH-1:0]   in_quot,
   output logic                 out_valid,
   output logic                 out_hit,
   output logic [WAY_OUT_W-1:0] out_way,
   output logic                 out_evicted,
   output logic [BLK_W-1:0]     out_block,
   output total_type            out_total
);

   localparam int WW = $clog2(WAYS);
   localparam int PW = 1 << WW;

   logic [WAYS-1:0]    valid_ff;
   logic [Q_WIDTH-1:0] block_ff [WAYS];
   count_type          count_ff [WAYS];
   total_type          hit_cnt_ff;

   logic               res_valid_ff;
   logic               res_hit_ff;
   logic [WW-1:0]      res_idx_ff;
   logic               res_evicted_ff;
   logic [BLK_W-1:0]   res_block_ff;

   logic [WAYS-1:0]    match;
   logic               any_hit;
   logic               any_empty;
   logic [WW-1:0]      hit_idx;
   logic [WW-1:0]      empty_idx;
   logic [WW-1:0]      sel_idx;
   count_type          tree_cnt [WW+1][PW];
   logic [WW-1:0]      tree_idx [WW+1][PW];

   always_comb begin
      any_hit   = 1'b0;
      any_empty = 1'b0;
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (block_ff[i] == in_quot);
         if (match[i]) begin
            any_hit = 1'b1;
            hit_idx = WW'(i);
         end
         if (!valid_ff[i]) begin
            any_empty = 1'b1;
            empty_idx = WW'(i);
         end
      end
   end

   // Minimum tree over use counts; the left (lower) side wins a tie.
   always_comb begin
      for (int lv = 0; lv <= WW; lv++) begin
         for (int j = 0; j < PW; j++) begin
            tree_cnt[lv][j] = CNT_MAX;
            tree_idx[lv][j] = '0;
         end
      end
      for (int j = 0; j < PW; j++) begin
         if (j < WAYS) begin
            tree_cnt[0][j] = count_ff[j];
         end
         tree_idx[0][j] = WW'(j);
      end
      for (int lv = 0; lv < WW; lv++) begin
         for (int j = 0; j < (PW >> (lv + 1)); j++) begin
            if (tree_cnt[lv][2*j+1] < tree_cnt[lv][2*j]) begin
               tree_cnt[lv+1][j] = tree_cnt[lv][2*j+1];
               tree_idx[lv+1][j] = tree_idx[lv][2*j+1];
            end else begin
               tree_cnt[lv+1][j] = tree_cnt[lv][2*j];
               tree_idx[lv+1][j] = tree_idx[lv][2*j];
            end
         end
      end
   end

   always_comb begin
      if (any_hit) begin
         sel_idx = hit_idx;
      end else if (any_empty) begin
         sel_idx = empty_idx;
      end else begin
         sel_idx = tree_idx[WW][0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hit_cnt_ff   <= '0;
         res_valid_ff <= 1'b0;
         for (int i = 0; i < WAYS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         res_valid_ff <= in_valid;
         if (in_valid) begin
            if (any_hit) begin
               if (count_ff[hit_idx] != CNT_MAX) begin
                  count_ff[hit_idx] <= count_ff[hit_idx] + CNT_ONE;
               end
               if (hit_cnt_ff != HIT_MAX) begin
                  hit_cnt_ff <= hit_cnt_ff + total_type'(1);
               end
            end else begin
               valid_ff[sel_idx] <= 1'b1;
               count_ff[sel_idx] <= CNT_ONE;
            end
         end
      end
      if (in_valid && !any_hit) begin
         block_ff[sel_idx] <= in_quot;
      end
      res_hit_ff     <= any_hit;
      res_idx_ff     <= sel_idx;
      res_evicted_ff <= !any_hit && !any_empty;
      res_block_ff   <= BLK_W'(in_quot);
   end

   assign out_valid   = res_valid_ff;
   assign out_hit     = res_hit_ff;
   assign out_way     = WAY_OUT_W'(res_idx_ff);
   assign out_evicted = res_evicted_ff;
   assign out_block   = res_block_ff;
   assign out_total   = hit_cnt_ff;

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_hit_ff |-> !res_evicted_ff)
      else $error("hit reported together with eviction");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_evicted_ff |-> $past(&valid_ff))
      else $error("eviction while an empty way existed");

   a_way_valid: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> valid_ff[res_idx_ff])
      else $error("reported way is not valid");

   a_miss_total: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && !res_hit_ff |-> hit_cnt_ff == $past(hit_cnt_ff))
      else $error("hit counter moved on a miss");

endmodule

// File: design/assoc_cache_lfu_tags.sv
// A result strobes on rsp_valid once the start transfer has passed the registered
//   constant-reciprocal division and the registered tag lookup and update.
// Throughput: one address per cycle; busy is never asserted.
// The receiver cannot stall: each result is on the rsp_ ports for exactly one cycle.
// Reset (synchronous, active high) empties all ways, clears use counts and the
//   hit counter, and drops any transfer in flight.
module assoc_cache_lfu_tags
   import aclt_pkg::*;
#(
   parameter int WAYS        = 4,
   parameter int BLOCK_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  addr_type             req_address,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [WAY_OUT_W-1:0] rsp_way,
   output logic                 rsp_evicted,
   output logic [BLK_W-1:0]     rsp_block_number,
   output total_type            rsp_hit_total
);

   // Width of the full block number; tags compare on all of it.
   localparam int Q_WIDTH = $clog2(64'(HIT_MAX) / 64'(BLOCK_BYTES) + 64'd1);

   logic               quot_valid;
   logic [Q_WIDTH-1:0] quot;

   // Every cycle can take a new address: the division is stateless and the
   // tag lookup reads its state combinationally and updates it on the edge that registers its result.
   assign busy = 1'b0;

   aclt_div #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .Q_WIDTH     (Q_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_address (req_address),
      .out_valid  (quot_valid),
      .out_quot   (quot)
   );

   // Hit search, empty-way search and least-used victim tree in one pass;
   // the selected way is updated and the result registered on the same edge.
   aclt_store #(
      .WAYS    (WAYS),
      .Q_WIDTH (Q_WIDTH)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (quot_valid),
      .in_quot     (quot),
      .out_valid   (rsp_valid),
      .out_hit     (rsp_hit),
      .out_way     (rsp_way),
      .out_evicted (rsp_evicted),
      .out_block   (rsp_block_number),
      .out_total   (rsp_hit_total)
   );

endmodule

// File: bench/lfu_tag_checker.sv
`timescale 1ns / 1ps
module lfu_tag_checker
   import aclt_pkg::*;
#(
   parameter int WAYS        = 4,
   parameter int BLOCK_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  addr_type             req_address,
   input  logic                 rsp_valid,
   input  logic                 rsp_hit,
   input  logic [WAY_OUT_W-1:0] rsp_way,
   input  logic                 rsp_evicted,
   input  logic [BLK_W-1:0]     rsp_block_number,
   input  total_type            rsp_hit_total,
   output int                   mismatch_count,
   output int                   pending_count
);

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 evicted;
      logic [BLK_W-1:0]     block_number;
      total_type            hit_total;
   } lookup_type;

   logic             tag_valid [WAYS];
   addr_type         tag_block [WAYS];
   count_type        tag_uses  [WAYS];
   total_type        hit_tally;
   lookup_type       expected_lookups [$];

   task automatic report_mismatch(input string text);
      $display("[%0t] %s", $time, text);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("rsp_%s: got 0x%0h, want 0x%0h", name, got, want));
   endtask

   // Look one address up in the tag store and update it: hit bumps the way's
   // use count and the hit tally; a miss fills the lowest empty way or evicts
   // the least used one. Tags hold the full quotient.
   function automatic lookup_type access_block(input addr_type address);
      lookup_type       r;
      addr_type         blk;
      logic             found;
      int               slot;
      blk       = address / BLOCK_BYTES;
      found     = 1'b0;
      slot      = 0;
      r.evicted = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if (!found && tag_valid[i] && tag_block[i] == blk) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (found) begin
         if (tag_uses[slot] != CNT_MAX) tag_uses[slot]++;
         if (hit_tally != HIT_MAX) hit_tally++;
      end else begin
         slot = -1;
         for (int i = 0; i < WAYS; i++) begin
            if (slot < 0 && !tag_valid[i]) slot = i;
         end
         if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < WAYS; i++) begin
               if (tag_uses[i] < tag_uses[slot]) slot = i;
            end
            r.evicted = 1'b1;
         end
         tag_valid[slot] = 1'b1;
         tag_block[slot] = blk;
         tag_uses[slot]  = CNT_ONE;
      end
      r.hit          = found;
      r.way          = WAY_OUT_W'(slot);
      r.block_number = BLK_W'(blk);
      r.hit_total    = hit_tally;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      lookup_type want;
      if (reset) begin
         for (int i = 0; i < WAYS; i++) begin
            tag_valid[i] = 1'b0;
            tag_uses[i]  = '0;
         end
         hit_tally = '0;
         mismatch_count = 0;
         expected_lookups.delete();
      end else begin
         // Retire the result first; it always belongs to an older transfer.
         if (rsp_valid) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch("result strobed with no lookup outstanding");
            end else begin
               want = expected_lookups.pop_front();
               check_field("hit", 32'(rsp_hit), 32'(want.hit));
               check_field("way", 32'(rsp_way), 32'(want.way));
               check_field("evicted", 32'(rsp_evicted), 32'(want.evicted));
               check_field("block_number", 32'(rsp_block_number), 32'(want.block_number));
               check_field("hit_total", rsp_hit_total, want.hit_total);
            end
         end
         if (start && !busy) expected_lookups.push_back(access_block(req_address));
      end
      pending_count = expected_lookups.size();
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import aclt_pkg::*;

   localparam int WAYS        = 4;
   localparam int BLOCK_BYTES = 8;
   localparam int POOL_SIZE   = 6;
   // A clean run spends most of its time in the idle-heavy phase and
   // ends well before this limit.
   localparam int CYCLE_LIMIT = 40000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   addr_type             req_address;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic [WAY_OUT_W-1:0] rsp_way;
   logic                 rsp_evicted;
   logic [BLK_W-1:0]     rsp_block_number;
   total_type            rsp_hit_total;
   int                   mismatch_count;
   int                   pending_count;
   int                   cycle_count = 0;

   // Block numbers that the random traffic keeps coming back to, so that
   // hits, fills and evictions all happen often.
   addr_type pool_blocks [POOL_SIZE];

   always #5 clock = ~clock;

   assoc_cache_lfu_tags #(
      .WAYS        (WAYS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way),
      .rsp_evicted      (rsp_evicted),
      .rsp_block_number (rsp_block_number),
      .rsp_hit_total    (rsp_hit_total)
   );

   lfu_tag_checker #(
      .WAYS        (WAYS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way),
      .rsp_evicted      (rsp_evicted),
      .rsp_block_number (rsp_block_number),
      .rsp_hit_total    (rsp_hit_total),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // Watchdog: a hung design or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Present one address and hold it until the block takes the transfer.
   // Idle cycles go in front, with start low; busy is sampled at the falling
   // edge, where it already holds the value the next rising edge will see.
   task automatic send_address(input addr_type address, input int idle_pct);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_address <= address;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
   endtask

   // Drop start and hold off until every outstanding lookup has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // Mostly pool blocks, skewed so a few are hot and the rest go cold and get
   // evicted; now and then a fully random address as noise.
   function automatic addr_type pool_address();
      int idx;
      if ($urandom_range(99) < 8) return addr_type'($urandom);
      idx = ($urandom_range(3) == 0) ? $urandom_range(POOL_SIZE - 1) : $urandom_range(2);
      return pool_blocks[idx] * BLOCK_BYTES + addr_type'($urandom_range(BLOCK_BYTES - 1));
   endfunction

   task automatic run_phase(input int items, input int idle_pct);
      for (int k = 0; k < items; k++) begin
         // Advance the working set now and then so new blocks push old ones out.
         if (k % 150 == 149)
            pool_blocks[$urandom_range(POOL_SIZE - 1)] = addr_type'($urandom) / BLOCK_BYTES;
         send_address(pool_address(), idle_pct);
      end
   endtask

   initial begin
      addr_type directed_addrs [17] = '{
         32'h0000_0000,   // empty store: fill way 0
         32'h0000_0007,   // same block, last byte: hit
         32'hFFFF_FFFF,   // top block: fill way 1
         32'hFFFF_FFF8,   // hit on the top block
         32'h8000_0000,   // fill way 2
         32'h0000_0008,   // neighbor of block 0: fill way 3
         32'h7FFF_FFFF,   // store full: ways 2 and 3 tie at one use, evict way 2
         32'h0000_000F,   // hit way 3
         32'h5555_5555,   // evict the fresh way 2 again
         32'hAAAA_AAAA,   // and again
         32'hAAAA_AAA8,   // hit way 2: every way now has two uses
         32'h1234_5678,   // four-way tie: evict way 0
         32'h1234_5678,
         32'h1234_567F,
         32'hFFFF_FFFC,
         32'hAAAA_AAAF,
         32'hDEAD_BEEF    // least used sits in the highest way
      };

      reset       <= 1'b1;
      start       <= 1'b0;
      req_address <= '0;
      foreach (pool_blocks[i]) pool_blocks[i] = addr_type'($urandom) / BLOCK_BYTES;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed corners: address extremes, fills, hits, ties and evictions.
      foreach (directed_addrs[i]) send_address(directed_addrs[i], 0);

      // Random traffic, sender idling about a third of the time.
      run_phase(640, 36);

      // Let the pipeline drain completely before going on.
      wait_drained();

      // Random traffic with a mostly idle sender.
      run_phase(640, 75);

      // Random traffic back to back.
      run_phase(600, 0);

      // Short back-to-back tail on a churned working set.
      run_phase(40, 0);

      wait_drained();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: assoc_cache_lfu_tags.f
design/aclt_pkg.sv
design/aclt_div.sv
design/aclt_store.sv
design/assoc_cache_lfu_tags.sv
bench/lfu_tag_checker.sv
bench/testbench.sv
